FILE: src/kwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyspace word generator package
// Constants for the generator: field widths, request, status and register codes, and
// default sizes for the top-level parameters.
// ----------------------------------------------------------------------------
package kwg_pkg;

	localparam int ALPHABET_DEPTH_DEF = 64;
	localparam int MAX_WORD_LEN_DEF   = 16;

	localparam int REQ_W     = 2;
	localparam int ENTRY_W   = 6;
	localparam int CHAR_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int ALEN_W    = 7;
	localparam int WLEN_W    = 5;
	localparam int INDEX_W   = 64;
	localparam int BITCNT_W  = $clog2(INDEX_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
	localparam logic [REQ_W-1:0] REQ_NEXT    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_CHAR      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ACK       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX    = 2'd3;

	localparam logic [ALEN_W-1:0]  ALEN_RESET  = 7'd26;
	localparam logic [WLEN_W-1:0]  WLEN_RESET  = 5'd4;

endpackage

FILE: src/keyspace_word_generator.sv
`timescale 1ns / 1ps
// Sequence: a load is acknowledged from S_RESP once the response slot is free; a restart
// runs the bit-serial divider over all 64 index bits for each of the n digits (n = word length).
// A next request runs up to n multiply steps in S_POW when end_index is zero, then S_CMP,
// then S_RD and S_WAIT for each character, stalling on rsp_stall, and up to n odometer steps.
// Only one request is in flight at a time; req_stall is high until the sequencer is back in idle.
// Reset loads the register defaults and clears digits, count and state; the alphabet is unset.
// ----------------------------------------------------------------------------
// Keyspace word generator
// Emits brute-force dictionary words over a loadable alphabet, one character
// per response, with a small sequencer around a bit-serial divider and a multiplier.
// ----------------------------------------------------------------------------
module keyspace_word_generator #(
	parameter int ALPHABET_DEPTH = kwg_pkg::ALPHABET_DEPTH_DEF,
	parameter int MAX_WORD_LEN   = kwg_pkg::MAX_WORD_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kwg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kwg_pkg::INDEX_W-1:0]    cfg_data,

	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [kwg_pkg::REQ_W-1:0]      req_type,
	input  logic [kwg_pkg::ENTRY_W-1:0]    entry_index,
	input  logic [kwg_pkg::CHAR_W-1:0]     entry_char,

	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [kwg_pkg::CHAR_W-1:0]     out_char,
	output logic                           last,
	output logic [kwg_pkg::STATUS_W-1:0]   status
);

	localparam int DW  = $clog2(ALPHABET_DEPTH);
	localparam int RXW = DW + 1;
	localparam int LW  = $clog2(MAX_WORD_LEN + 1);
	localparam int IW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int XW  = kwg_pkg::INDEX_W;
	localparam int PW  = XW + RXW;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV  = 8'b0000_0010,
		S_POW  = 8'b0000_0100,
		S_CMP  = 8'b0000_1000,
		S_RD   = 8'b0001_0000,
		S_WAIT = 8'b0010_0000,
		S_INC  = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [kwg_pkg::ALEN_W-1:0] alphabet_len_q;
	logic [kwg_pkg::WLEN_W-1:0] word_len_q;
	logic [XW-1:0]              start_index_q;
	logic [XW-1:0]              end_index_q;

	logic [DW-1:0]                 digit_q [MAX_WORD_LEN];
	logic [XW-1:0]                 word_count_q;
	logic [LW-1:0]                 cnt_q;
	logic [kwg_pkg::BITCNT_W-1:0]  bit_q;
	logic [kwg_pkg::STATUS_W-1:0]  resp_q;

	// Divider and range registers carry no reset.
	logic [XW-1:0] dq_q;
	logic [DW-1:0] rem_q;
	logic [XW-1:0] limit_q;

	logic                            rsp_valid_q;
	logic [kwg_pkg::CHAR_W-1:0]      out_char_q;
	logic                            last_q;
	logic [kwg_pkg::STATUS_W-1:0]    status_q;

	logic [RXW-1:0] radix;
	logic [LW-1:0]  wlen;
	logic [LW-1:0]  wlen_m1;
	logic [IW-1:0]  idx;
	logic [DW-1:0]  cur_digit;
	logic [DW-1:0]  fix_digit;
	logic [RXW-1:0] inc_sum;
	logic           inc_wrap;
	logic [RXW-1:0] div_t;
	logic           div_ge;
	logic [RXW-1:0] div_rem;
	logic [XW-1:0]  div_dq;
	logic [PW-1:0]  pow_prod;
	logic           pow_ovf;
	logic           req_accept;
	logic           load_en;
	logic           slot_free;
	logic           cnt_last;
	logic [kwg_pkg::CHAR_W-1:0] ram_rd_data;

	// Effective radix and word length after range repair.
	always_comb begin
		if (alphabet_len_q == '0) begin
			radix = RXW'(1);
		end else if (int'(alphabet_len_q) > ALPHABET_DEPTH) begin
			radix = RXW'(ALPHABET_DEPTH);
		end else begin
			radix = RXW'(alphabet_len_q);
		end
		if (word_len_q == '0) begin
			wlen = LW'(1);
		end else if (int'(word_len_q) > MAX_WORD_LEN) begin
			wlen = LW'(MAX_WORD_LEN);
		end else begin
			wlen = LW'(word_len_q);
		end
	end

	assign wlen_m1   = wlen - LW'(1);
	assign idx       = cnt_q[IW-1:0];
	assign cnt_last  = (cnt_q == wlen_m1);
	assign cur_digit = digit_q[idx];
	// A digit left at or above a smaller radix reads as zero.
	assign fix_digit = ({1'b0, cur_digit} >= radix) ? '0 : cur_digit;
	assign inc_sum   = {1'b0, cur_digit} + RXW'(1);
	assign inc_wrap  = (inc_sum >= radix);

	// One restoring division step: the dividend shifts out as the quotient shifts in.
	assign div_t   = {rem_q, dq_q[XW-1]};
	assign div_ge  = (div_t >= radix);
	assign div_rem = div_ge ? (div_t - radix) : div_t;
	assign div_dq  = {dq_q[XW-2:0], div_ge};

	assign pow_prod = {{RXW{1'b0}}, limit_q} * {{XW{1'b0}}, radix};
	assign pow_ovf  = (pow_prod[PW-1:XW] != '0);

	assign req_accept = req_valid && !req_stall;
	assign load_en    = req_accept && (req_type == kwg_pkg::REQ_LOAD) &&
	                    (int'(entry_index) < ALPHABET_DEPTH);
	assign slot_free  = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	kwg_ram #(
		.WIDTH (kwg_pkg::CHAR_W),
		.DEPTH (ALPHABET_DEPTH)
	) u_alphabet (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (DW'(entry_index)),
		.wr_data (entry_char),
		.rd_addr (fix_digit),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_len_q <= kwg_pkg::ALEN_RESET;
			word_len_q     <= kwg_pkg::WLEN_RESET;
			start_index_q  <= '0;
			end_index_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kwg_pkg::CFG_ALPHABET_LEN: begin
					alphabet_len_q <= cfg_data[kwg_pkg::ALEN_W-1:0];
				end
				kwg_pkg::CFG_WORD_LEN: begin
					word_len_q <= cfg_data[kwg_pkg::WLEN_W-1:0];
				end
				kwg_pkg::CFG_START_INDEX: begin
					start_index_q <= cfg_data;
				end
				kwg_pkg::CFG_END_INDEX: begin
					end_index_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			word_count_q <= '0;
			cnt_q        <= '0;
			bit_q        <= '0;
			resp_q       <= kwg_pkg::ST_ACK;
			rsp_valid_q  <= 1'b0;
			for (int i = 0; i < MAX_WORD_LEN; i++) begin
				digit_q[i] <= '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						case (req_type)
							kwg_pkg::REQ_LOAD: begin
								resp_q  <= kwg_pkg::ST_ACK;
								state_q <= S_RESP;
							end
							kwg_pkg::REQ_RESTART: begin
								for (int i = 0; i < MAX_WORD_LEN; i++) begin
									digit_q[i] <= '0;
								end
								word_count_q <= start_index_q;
								cnt_q        <= wlen_m1;
								bit_q        <= '0;
								state_q      <= S_DIV;
							end
							kwg_pkg::REQ_NEXT: begin
								cnt_q   <= '0;
								state_q <= (end_index_q == '0) ? S_POW : S_CMP;
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == '1) begin
						digit_q[idx] <= div_rem[DW-1:0];
						if (cnt_q == '0) begin
							resp_q  <= kwg_pkg::ST_ACK;
							state_q <= S_RESP;
						end else begin
							cnt_q <= cnt_q - LW'(1);
						end
					end
				end
				S_POW: begin
					// Full range is radix ** length, saturating at the top of the count.
					if (pow_ovf || cnt_last) begin
						state_q <= S_CMP;
					end
					cnt_q <= cnt_q + LW'(1);
				end
				S_CMP: begin
					cnt_q <= '0;
					if (word_count_q >= limit_q) begin
						resp_q  <= kwg_pkg::ST_EXHAUSTED;
						state_q <= S_RESP;
					end else begin
						word_count_q <= word_count_q + XW'(1);
						state_q      <= S_RD;
					end
				end
				S_RD: begin
					digit_q[idx] <= fix_digit;
					state_q      <= S_WAIT;
				end
				S_WAIT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						if (cnt_last) begin
							state_q <= S_INC;
						end else begin
							cnt_q   <= cnt_q + LW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_INC: begin
					digit_q[idx] <= inc_wrap ? '0 : inc_sum[DW-1:0];
					if (!inc_wrap || cnt_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q - LW'(1);
					end
				end
				S_RESP: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_accept && req_type == kwg_pkg::REQ_RESTART) begin
					dq_q  <= start_index_q;
					rem_q <= '0;
				end
				if (req_accept && req_type == kwg_pkg::REQ_NEXT) begin
					limit_q <= (end_index_q == '0) ? XW'(1) : end_index_q;
				end
			end
			S_DIV: begin
				dq_q  <= div_dq;
				rem_q <= (bit_q == '1) ? '0 : div_rem[DW-1:0];
			end
			S_POW: begin
				limit_q <= pow_ovf ? '1 : pow_prod[XW-1:0];
			end
			S_WAIT: begin
				if (slot_free) begin
					out_char_q <= ram_rd_data;
					last_q     <= cnt_last;
					status_q   <= kwg_pkg::ST_CHAR;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					out_char_q <= '0;
					last_q     <= 1'b1;
					status_q   <= resp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;
	assign status    = status_q;

endmodule

FILE: src/kwg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kwg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
